>>> rtl/amws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amws_pkg
// Shared constants and controller/datapath interface types for the alarm
// table with snooze.
// ----------------------------------------------------------------------------
package amws_pkg;

	localparam int ALARM_ENTRIES_DEF = 8;

	// action codes
	localparam logic [1:0] ACT_PROGRAM = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	// register indexes
	localparam logic REG_SNOOZE_MINUTES = 1'b0;
	localparam logic REG_SNOOZE_MAX     = 1'b1;

	localparam int ONE_SHOT_BIT = 7;
	localparam int MATCH_BITS   = 8;

	typedef struct packed {
		logic capture;   // latch the input beat
		logic exec;      // apply program / countdown / timeout
		logic scan;      // compare one table entry
		logic load_out;  // move result into the output register
	} amws_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic scan_last;
		logic out_free;
	} amws_status_t;

endpackage

>>> rtl/amws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amws_ctrl
// Sequencer: accept a beat, execute it, scan the table on a minute tick,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module amws_ctrl
	import amws_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  amws_status_t status,
	output amws_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		cmd.scan     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.is_tick ? S_SCAN : S_FIN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/amws_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amws_dp
// Datapath: input capture, alarm table with per-entry valid bits, snooze
// counters, one-entry-per-cycle match scan and the output register.
// ----------------------------------------------------------------------------
module amws_dp
	import amws_pkg::*;
#(
	parameter int ALARM_ENTRIES = ALARM_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  amws_cmd_t    cmd,
	output amws_status_t status,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic [7:0]   cfg_wdata,
	input  logic [1:0]   action,
	input  logic [2:0]   entry_index,
	input  logic [4:0]   hour,
	input  logic [5:0]   minute,
	input  logic [2:0]   weekday,
	input  logic [7:0]   repeat_mask,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         ring_start,
	output logic         ring_stop,
	output logic [7:0]   matched_mask,
	output logic [7:0]   snoozes_left
);

	localparam int IDX_W = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_ENTRIES - 1);

	// config registers
	logic [7:0] snooze_minutes_q;
	logic [7:0] snooze_max_q;

	// captured beat
	logic [1:0] action_q;
	logic [2:0] entry_index_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [2:0] weekday_q;
	logic [7:0] repeat_mask_q;

	// table; entries without a valid bit read as zero
	logic [ALARM_ENTRIES-1:0] valid_q;
	logic [4:0]               hour_tab_q [ALARM_ENTRIES];
	logic [5:0]               min_tab_q  [ALARM_ENTRIES];
	logic [7:0]               mask_tab_q [ALARM_ENTRIES];

	logic [7:0]       countdown_q;
	logic [7:0]       remaining_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             start_q;
	logic [7:0]       matched_q;

	logic             out_valid_q;
	logic             ring_start_q;
	logic             ring_stop_q;
	logic [7:0]       matched_mask_q;
	logic [7:0]       snoozes_left_q;

	logic             prog_ok;
	logic [IDX_W-1:0] prog_idx;
	logic [4:0]       rd_hour;
	logic [5:0]       rd_min;
	logic [7:0]       rd_mask;
	logic             day_ok;
	logic             hit;
	logic             do_prog;
	logic             do_hit;

	assign prog_ok  = ({3'b000, entry_index_q} < 6'(ALARM_ENTRIES));
	assign prog_idx = IDX_W'(entry_index_q);
	assign do_prog  = cmd.exec && (action_q == ACT_PROGRAM) && prog_ok;

	always_comb begin
		rd_hour = '0;
		rd_min  = '0;
		rd_mask = '0;
		if (valid_q[scan_idx_q]) begin
			rd_hour = hour_tab_q[scan_idx_q];
			rd_min  = min_tab_q[scan_idx_q];
			rd_mask = mask_tab_q[scan_idx_q];
		end
	end

	// weekday 7 has no mask bit; only one-shot can match then
	assign day_ok = rd_mask[ONE_SHOT_BIT] ||
		((weekday_q != 3'd7) && rd_mask[weekday_q]);
	assign hit    = day_ok && (rd_hour == hour_q) && (rd_min == minute_q);
	assign do_hit = cmd.scan && hit;

	assign status.is_tick   = (action_q == ACT_TICK);
	assign status.scan_last = (scan_idx_q == LAST_IDX);
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snooze_minutes_q <= '0;
			snooze_max_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SNOOZE_MINUTES: snooze_minutes_q <= cfg_wdata;
				REG_SNOOZE_MAX:     snooze_max_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q      <= action;
			entry_index_q <= entry_index;
			hour_q        <= hour;
			minute_q      <= minute;
			weekday_q     <= weekday;
			repeat_mask_q <= repeat_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_prog) begin
			valid_q[prog_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_prog) begin
			hour_tab_q[prog_idx] <= hour_q;
			min_tab_q[prog_idx]  <= minute_q;
			mask_tab_q[prog_idx] <= repeat_mask_q;
		end else if (do_hit) begin
			mask_tab_q[scan_idx_q][ONE_SHOT_BIT] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			remaining_q <= '0;
			scan_idx_q  <= '0;
			start_q     <= 1'b0;
			matched_q   <= '0;
		end else begin
			if (cmd.capture) begin
				start_q    <= 1'b0;
				matched_q  <= '0;
				scan_idx_q <= '0;
			end
			if (cmd.exec) begin
				case (action_q)
					ACT_TICK: begin
						if (countdown_q != 8'd0) begin
							countdown_q <= countdown_q - 8'd1;
							if ((countdown_q == 8'd1) && (remaining_q != 8'd0)) begin
								remaining_q <= remaining_q - 8'd1;
								start_q     <= 1'b1;
							end
						end
					end
					ACT_TIMEOUT: begin
						countdown_q <= snooze_minutes_q;
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (hit) begin
					start_q     <= 1'b1;
					remaining_q <= snooze_max_q;
					for (int b = 0; b < MATCH_BITS; b++) begin
						if (32'(scan_idx_q) == b) begin
							matched_q[b] <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ring_start_q   <= start_q && (action_q == ACT_TICK);
			ring_stop_q    <= (action_q == ACT_TIMEOUT);
			matched_mask_q <= (action_q == ACT_TICK) ? matched_q : 8'd0;
			snoozes_left_q <= remaining_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ring_start   = ring_start_q;
	assign ring_stop    = ring_stop_q;
	assign matched_mask = matched_mask_q;
	assign snoozes_left = snoozes_left_q;

endmodule

>>> rtl/alarm_match_with_snooze.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_match_with_snooze
// Alarm table with one-shot / weekday repeat and a snooze counter.
//
// Input channel (in_valid/in_ready) takes one beat per action: program an
// entry, minute tick, or ring timeout. Output channel (out_valid/out_ready)
// returns exactly one result beat per input beat, in order.
// Config port: cfg_we writes cfg_wdata to register cfg_addr
// (0 snooze minutes, 1 snooze max count) in the same cycle; write only
// while the block is idle.
// Sequence: a minute tick goes from accept through the execute state, the
// table scan (one table entry compared per cycle), result load and back
// to idle; program and timeout beats skip the scan. Result load waits
// while the output register is still full.
// An output register holds the finished result, so the next beat is
// accepted while it waits; a stalled receiver keeps the following result
// in the datapath, the controller waiting, until the register frees.
// Reset clears the table valid bits, snooze counters and config registers.
// ----------------------------------------------------------------------------
module alarm_match_with_snooze
	import amws_pkg::*;
#(
	parameter int ALARM_ENTRIES = ALARM_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_addr,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [2:0] entry_index,
	input  logic [4:0] hour,
	input  logic [5:0] minute,
	input  logic [2:0] weekday,
	input  logic [7:0] repeat_mask,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       ring_start,
	output logic       ring_stop,
	output logic [7:0] matched_mask,
	output logic [7:0] snoozes_left
);

	amws_cmd_t    cmd;
	amws_status_t status;

	amws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	amws_dp #(
		.ALARM_ENTRIES (ALARM_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.action       (action),
		.entry_index  (entry_index),
		.hour         (hour),
		.minute       (minute),
		.weekday      (weekday),
		.repeat_mask  (repeat_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ring_start   (ring_start),
		.ring_stop    (ring_stop),
		.matched_mask (matched_mask),
		.snoozes_left (snoozes_left)
	);

endmodule
